@@ src/speck_pkg.sv @@
// Shared types, constants and round functions for the SPECK 64/128 encryption unit.
`timescale 1ns / 1ps
`default_nettype none

package speck_pkg;

    localparam int WORD_W = 32;
    localparam int ROUNDS = 27;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_KEY_K0 = 2'd0,
        REG_KEY_L0 = 2'd1,
        REG_KEY_L1 = 2'd2,
        REG_KEY_L2 = 2'd3
    } cfg_reg_t;

    // Block half-words as they travel down the pipeline.
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } word_pair_t;

    // Key schedule state: current round key and the queue of schedule words,
    // with l0 the word used by the next schedule step.
    typedef struct packed {
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] l0;
        logic [WORD_W-1:0] l1;
        logic [WORD_W-1:0] l2;
    } key_state_t;

    function automatic logic [WORD_W-1:0] rotr8(input logic [WORD_W-1:0] v);
        return {v[7:0], v[WORD_W-1:8]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] v);
        return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
    endfunction

    // One SPECK round on (x, y) with round key k.
    function automatic word_pair_t speck_mix(input logic [WORD_W-1:0] x,
                                             input logic [WORD_W-1:0] y,
                                             input logic [WORD_W-1:0] k);
        word_pair_t res;
        res.x = (rotr8(x) + y) ^ k;
        res.y = rotl3(y) ^ res.x;
        return res;
    endfunction

    // One key schedule step: the round function applied to (l0, k) with the
    // step counter as its key; the updated word goes to the back of the queue.
    function automatic key_state_t key_step(input key_state_t ks,
                                            input logic [WORD_W-1:0] ctr);
        word_pair_t mixed;
        key_state_t res;
        mixed  = speck_mix(ks.l0, ks.k, ctr);
        res.k  = mixed.y;
        res.l0 = ks.l1;
        res.l1 = ks.l2;
        res.l2 = mixed.x;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/speck64_128_encrypt_unit.sv @@
// Top level of the SPECK 64/128 encryption unit: key registers and the round pipeline.
`timescale 1ns / 1ps
`default_nettype none

// A transaction accepted on the input side passes through one register stage per cipher
// round before it can be taken on the output side. Throughput: one block per cycle while
// the output takes blocks; every stage moves on as soon as the stage after it has room,
// so bubbles are squeezed out and a stall at the output loses and repeats nothing.
// Reset: rst_n clears the stage valid bits and all four key words to zero; the key
// schedule travels with each block, so a new block may follow a key write at once.
module speck64_128_encrypt_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration write port.
    input  wire logic                       cfg_we,
    input  wire speck_pkg::cfg_reg_t        cfg_index,
    input  wire logic [speck_pkg::WORD_W-1:0] cfg_data,
    // Plaintext stream.
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [2*speck_pkg::WORD_W-1:0] s_axis_tdata,  // pt_high [31:0], pt_low [63:32]
    // Ciphertext stream.
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [2*speck_pkg::WORD_W-1:0]  m_axis_tdata   // ct_high [31:0], ct_low [63:32]
);
    import speck_pkg::*;

    // ------------------------------------------------------------------
    // Key registers. The user is to write them only while the pipeline is empty;
    // the block does not enforce this. The key words feed the first stage directly.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] key_k0_reg;
    logic [WORD_W-1:0] key_l0_reg;
    logic [WORD_W-1:0] key_l1_reg;
    logic [WORD_W-1:0] key_l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_k0_reg <= '0;
            key_l0_reg <= '0;
            key_l1_reg <= '0;
            key_l2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_K0: key_k0_reg <= cfg_data;
                REG_KEY_L0: key_l0_reg <= cfg_data;
                REG_KEY_L1: key_l1_reg <= cfg_data;
                REG_KEY_L2: key_l2_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Round pipeline. Stage s holds the block after round s and, for all
    // but the last stage, the key schedule state giving round key s+1.
    // Each stage but the last computes one data round and one key schedule step
    // side by side; both are an add followed by XORs and fixed rotations.
    // ------------------------------------------------------------------
    key_state_t        ks_cfg;
    word_pair_t        blk_in;

    word_pair_t        dat_reg  [ROUNDS];
    word_pair_t        dat_next [ROUNDS];
    key_state_t        ks_reg   [ROUNDS-1];
    key_state_t        ks_next  [ROUNDS-1];
    logic [ROUNDS-1:0] vld_reg;
    logic [ROUNDS-1:0] vld_next;

    // A stage may load when it is empty or its content moves on this cycle.
    logic [ROUNDS:0]   stage_rdy;

    assign ks_cfg.k  = key_k0_reg;
    assign ks_cfg.l0 = key_l0_reg;
    assign ks_cfg.l1 = key_l1_reg;
    assign ks_cfg.l2 = key_l2_reg;

    assign blk_in.x  = s_axis_tdata[WORD_W-1:0];
    assign blk_in.y  = s_axis_tdata[2*WORD_W-1:WORD_W];

    assign stage_rdy[ROUNDS] = m_axis_tready;

    for (genvar s = 0; s < ROUNDS; s++)
    begin : g_stage
        key_state_t ks_in;
        word_pair_t dat_in;

        if (s == 0)
        begin : g_first
            assign ks_in       = ks_cfg;
            assign dat_in      = blk_in;
            assign vld_next[s] = s_axis_tvalid;
        end
        else
        begin : g_inner
            assign ks_in       = ks_reg[s-1];
            assign dat_in      = dat_reg[s-1];
            assign vld_next[s] = vld_reg[s-1];
        end

        assign stage_rdy[s] = !vld_reg[s] || stage_rdy[s+1];
        assign dat_next[s]  = speck_mix(dat_in.x, dat_in.y, ks_in.k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (stage_rdy[s])
            begin
                vld_reg[s] <= vld_next[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_rdy[s])
            begin
                dat_reg[s] <= dat_next[s];
            end
        end

        // The last round needs no further round key.
        if (s < ROUNDS - 1)
        begin : g_key
            assign ks_next[s] = key_step(ks_in, WORD_W'(s));

            always_ff @(posedge clk)
            begin
                if (stage_rdy[s])
                begin
                    ks_reg[s] <= ks_next[s];
                end
            end
        end
    end

    assign s_axis_tready = stage_rdy[0];
    assign m_axis_tvalid = vld_reg[ROUNDS-1];
    assign m_axis_tdata  = {dat_reg[ROUNDS-1].y, dat_reg[ROUNDS-1].x};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Back-pressure reaches the input only when every stage holds a block.
    a_full_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ($countones(vld_reg) == ROUNDS)
    ) else $error("input stalled while the pipeline has a free stage");

    // Blocks in flight change only by what enters and what leaves.
    a_occupancy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(vld_reg) ==
             $countones($past(vld_reg)) + int'($past(in_acc)) - int'($past(out_acc)))
    ) else $error("block lost or duplicated inside the pipeline");

    // A block waiting at the output stays there until it is taken.
    a_out_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(dat_reg[ROUNDS-1]))
    ) else $error("stalled output stage was overwritten");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the SPECK 64/128 encryption unit.
`timescale 1ns / 1ps

module testbench;

    import speck_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 12;
    localparam int BLOCKS_PER_PH = 78;
    localparam int HOLD_CYCLES   = 300;

    // One row of the directed stimulus. The key is written as {l2, l1, l0, k0} so that it
    // reads in the same order as the published test vectors. Where has_ct is set, the
    // ciphertext is taken from the row instead of from the predictor.
    typedef struct packed {
        logic         set_key;
        logic [127:0] key;
        logic [31:0]  pt_high;
        logic [31:0]  pt_low;
        logic         has_ct;
        logic [31:0]  ct_high;
        logic [31:0]  ct_low;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 12;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // All-zero key straight after reset, plaintext extremes.
        '{1'b0, 128'h0, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'hffffffff, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0, 32'h0},
        // Published SPECK 64/128 vector.
        '{1'b1, 128'h1b1a1918_13121110_0b0a0908_03020100, 32'h3b726574, 32'h7475432d,
          1'b1, 32'h8c6fa548, 32'h454e028b},
        '{1'b0, 128'h0, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        // All-ones key.
        '{1'b1, {128{1'b1}}, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        // Only k0 set, the schedule words left at zero.
        '{1'b1, 128'h00000000_00000000_00000000_ffffffff, 32'h12345678, 32'h9abcdef0,
          1'b0, 32'h0, 32'h0},
        '{1'b0, 128'h0, 32'h00000001, 32'h80000000, 1'b0, 32'h0, 32'h0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [WORD_W-1:0]     cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [2*WORD_W-1:0]   s_axis_tdata;   // pt_high [31:0], pt_low [63:32]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [2*WORD_W-1:0]   m_axis_tdata;   // ct_high [31:0], ct_low [63:32]

    // The testbench's own copy of the key words and the round keys expanded from them.
    logic [WORD_W-1:0]     key_words [4];
    logic [WORD_W-1:0]     round_key_copy [ROUNDS];

    // Ciphertexts still owed by the block, oldest first.
    word_pair_t            pending_ct [$];
    word_pair_t            ct_want;

    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           sender_idle_pct;
    int unsigned           recv_idle_pct = 0;
    logic                  pressure_phase = 1'b0;
    int unsigned           hold_left = 0;
    logic                  hold_done = 1'b0;

    speck64_128_encrypt_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // One cipher round: rotate x right by eight, add y, mix in the key, then rotate y left
    // by three and fold the new x into it. The key schedule uses the same round.
    function automatic word_pair_t cipher_round(input logic [WORD_W-1:0] x,
                                                input logic [WORD_W-1:0] y,
                                                input logic [WORD_W-1:0] k);
        word_pair_t res;
        res.x = ({x[7:0], x[WORD_W-1:8]} + y) ^ k;
        res.y = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ res.x;
        return res;
    endfunction

    // Rebuilds the round keys from the key words. The three schedule words are used in
    // turn, and the round counter serves as the key of each schedule step. Only as many
    // round keys are produced as there are rounds, so the last step is never taken.
    function automatic void expand_round_keys();
        logic [WORD_W-1:0] sched [3];
        logic [WORD_W-1:0] k;
        word_pair_t        mixed;
        int                i;
        k         = key_words[0];
        sched[0]  = key_words[1];
        sched[1]  = key_words[2];
        sched[2]  = key_words[3];
        round_key_copy[0] = k;
        for (i = 0; i < ROUNDS - 1; i++)
        begin
            mixed        = cipher_round(sched[i % 3], k, WORD_W'(i));
            sched[i % 3] = mixed.x;
            k            = mixed.y;
            round_key_copy[i + 1] = k;
        end
    endfunction

    function automatic word_pair_t encrypt_block(input logic [WORD_W-1:0] pt_high,
                                                 input logic [WORD_W-1:0] pt_low);
        word_pair_t blk;
        int         r;
        blk.x = pt_high;
        blk.y = pt_low;
        for (r = 0; r < ROUNDS; r++)
            blk = cipher_round(blk.x, blk.y, round_key_copy[r]);
        return blk;
    endfunction

    // Mostly uniform words, with zero, all ones and single set bits mixed in.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Offers one plaintext block and returns at the edge at which it is accepted. The
    // expected ciphertext is queued at that edge. A gap of a few idle cycles may come first;
    // each cycle is idle with the sender's idle chance, so that share of cycles is idle.
    task automatic send_block(input logic [WORD_W-1:0] pt_high,
                              input logic [WORD_W-1:0] pt_low,
                              input logic              use_given,
                              input word_pair_t        given_ct);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pt_low, pt_high};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_ct.push_back(use_given ? given_ct : encrypt_block(pt_high, pt_low));
    endtask

    // Stops offering blocks and waits until every queued ciphertext has come out, so that
    // the key registers may be written with nothing in flight.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_ct.size() != 0)
            @(posedge clk);
    endtask

    // Writes one key register and brings the testbench's own key copy up to date. The
    // caller lowers the write enable once its run of writes is over.
    task automatic write_key_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        key_words[idx] = value;
        expand_round_keys();
        @(posedge clk);
    endtask

    // Loads a whole key given as {l2, l1, l0, k0}.
    task automatic load_key(input logic [127:0] key);
        write_key_reg(REG_KEY_K0, key[31:0]);
        write_key_reg(REG_KEY_L0, key[63:32]);
        write_key_reg(REG_KEY_L1, key[95:64]);
        write_key_reg(REG_KEY_L2, key[127:96]);
        cfg_we <= 1'b0;
    endtask

    // Receiver. It takes ciphertexts with a chance of stalling set per phase. Once, in the
    // pressure phase, it holds off for a long stretch of its own counting while the sender
    // goes on offering blocks, so that the pipeline fills and the input side stalls.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (pressure_phase && !hold_done)
        begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every accepted ciphertext is matched against the oldest expectation, word by word.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_ct.size() == 0)
            begin
                $display("%0t: ciphertext with nothing expected: expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                ct_want = pending_ct.pop_front();
                if (m_axis_tdata[WORD_W-1:0] !== ct_want.x)
                begin
                    $display("%0t: ct_high mismatch: expected %h, actual %h",
                             $time, ct_want.x, m_axis_tdata[WORD_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2*WORD_W-1:WORD_W] !== ct_want.y)
                begin
                    $display("%0t: ct_low mismatch: expected %h, actual %h",
                             $time, ct_want.y, m_axis_tdata[2*WORD_W-1:WORD_W]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a run that hangs is a failed run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence. The index port is two bits wide, so every index names a key word, and
    // the data port is a single word, so no written value can be too wide for its register.
    initial
    begin
        int         row;
        int         ph;
        int         n;
        stim_row_t  cur;
        word_pair_t typed_ct;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_KEY_K0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        sender_idle_pct = 17;
        for (n = 0; n < 4; n++)
            key_words[n] = '0;
        expand_round_keys();

        repeat (2) @(posedge clk);
        rst_n         <= 1'b1;
        recv_idle_pct <= 59;
        @(posedge clk);

        // Directed part: the reset key first, then keys written between rows, each write
        // taking effect for the very next block.
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            cur = DIRECTED[row];
            if (cur.set_key)
            begin
                wait_until_drained();
                load_key(cur.key);
            end
            typed_ct.x = cur.ct_high;
            typed_ct.y = cur.ct_low;
            send_block(cur.pt_high, cur.pt_low, cur.has_ct, typed_ct);
        end

        // Random part. The first third runs with a slow receiver, the second with a slow
        // sender and the last with neither idling; the long receiver hold-off falls in the
        // last third, where the sender streams at full rate. Each phase starts with the
        // pipeline drained and a fresh key setting.
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_until_drained();
            if (ph == PHASES / 3)
            begin
                sender_idle_pct = 59;
                recv_idle_pct  <= 17;
            end
            else if (ph == 2 * PHASES / 3)
            begin
                sender_idle_pct = 0;
                recv_idle_pct  <= 0;
            end
            pressure_phase <= (ph == 2 * PHASES / 3 + 1);

            if (ph == 0)
                load_key({128{1'b1}});
            else if (ph == 1)
                load_key('0);
            else if (ph % 2 == 1)
            begin
                // A single key word changes; the round keys must follow at once.
                write_key_reg(cfg_reg_t'($urandom_range(0, 3)), pick_word());
                cfg_we <= 1'b0;
            end
            else
                load_key({pick_word(), pick_word(), pick_word(), pick_word()});

            for (n = 0; n < BLOCKS_PER_PH; n++)
                send_block(pick_word(), pick_word(), 1'b0, typed_ct);
        end

        wait_until_drained();
        repeat (ROUNDS + 10) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
